@@ hw/rtl/cks_pkg.sv @@
`timescale 1ns / 1ps
package cks_pkg;

  localparam int MCAND_W = 34;
  localparam int MIER_W = 24;
  localparam int PROD_W = MCAND_W + 1 + MIER_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG = 2'd2;

  localparam logic signed [MCAND_W-1:0] TRIG_GAIN = 34'sd652032874;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TURN_A,
    S_TURN_B,
    S_ACCEL,
    S_TRIG,
    S_VX,
    S_VY,
    S_DRAG_X,
    S_DRAG_Y,
    S_DONE
  } state_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/cks_serial_mult.sv @@
`timescale 1ns / 1ps
module cks_serial_mult
  import cks_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [MIER_W-1:0]         mier,
  output logic                      done,
  output logic signed [PROD_W-1:0]  prod
);

  localparam int CntW = $clog2(MIER_W);

  logic                      running;
  logic [CntW-1:0]           cnt;
  logic signed [MCAND_W-1:0] mc;
  logic [MIER_W-1:0]         mr;
  logic signed [MCAND_W:0]   acc_hi;
  logic [MIER_W-1:0]         acc_lo;
  logic signed [MCAND_W:0]   addend;
  logic signed [MCAND_W:0]   sum;

  assign addend = mr[0] ? {mc[MCAND_W-1], mc} : '0;
  assign sum = acc_hi + addend;
  assign prod = {acc_hi, acc_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      running <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == CntW'(MIER_W - 1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      mr <= mier;
      acc_hi <= '0;
      acc_lo <= '0;
    end else if (running) begin
      mr <= {1'b0, mr[MIER_W-1:1]};
      acc_hi <= {sum[MCAND_W], sum[MCAND_W:1]};
      acc_lo <= {sum[0], acc_lo[MIER_W-1:1]};
    end
  end

endmodule

@@ hw/rtl/cks_cordic.sv @@
`timescale 1ns / 1ps
module cks_cordic
  import cks_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               angle,
  output logic                      done,
  output logic signed [MCAND_W-1:0] cos_val,
  output logic signed [MCAND_W-1:0] sin_val
);

  localparam int IdxW = $clog2(CORDIC_STEPS);

  logic                      running;
  logic [IdxW-1:0]           cnt;
  logic [1:0]                quad;
  logic signed [MCAND_W-1:0] x;
  logic signed [MCAND_W-1:0] y;
  logic signed [32:0]        z;
  logic [1:0]                quad_in;
  logic [31:0]               resid;
  logic signed [MCAND_W-1:0] xs;
  logic signed [MCAND_W-1:0] ys;
  logic signed [32:0]        step_ang;

  assign quad_in = 2'((angle + 32'h2000_0000) >> 30);
  assign resid = angle - {quad_in, 30'd0};
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign step_ang = $signed({3'b000, atan_entry(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      running <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == IdxW'(CORDIC_STEPS - 1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= quad_in;
      x <= TRIG_GAIN;
      y <= '0;
      z <= {resid[31], resid};
    end else if (running) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_ang;
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin
        cos_val = x;
        sin_val = y;
      end
      2'd1: begin
        cos_val = -y;
        sin_val = x;
      end
      2'd2: begin
        cos_val = -x;
        sin_val = -y;
      end
      default: begin
        cos_val = y;
        sin_val = -x;
      end
    endcase
  end

endmodule

@@ hw/rtl/car_kinematic_step_unit.sv @@
`timescale 1ns / 1ps
// Kinematic step of a point-mass car, one simulation tick per request.
// Input channel: in_valid / in_stall carry dt and steer; in_stall is high
// while a tick is being worked, so one request is in flight at a time.
// Output channel: out_valid / out_stall carry the new position, velocity
// and heading; the result is held in an output register until taken, and
// the next request may be accepted while it waits.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; write
// only while no request is in flight. Index 0 angular gain, 1 linear gain,
// 2 drag factor; other indexes are ignored. cfg_ready is always high.
// The one bit-serial multiplier (seven products per tick) and the
// one-step-per-cycle CORDIC (CORDIC_STEPS steps) work in turn, never both.
// A stall on the output holds the finished tick in its final state until
// the previous result is taken.
// Reset clears position, velocity and heading to zero, angular and linear
// gains to zero, drag factor to 65535, and drops any pending result.
module car_kinematic_step_unit
  import cks_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          dt,
  input  logic signed [15:0]   steer,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   pos_x,
  output logic signed [31:0]   pos_y,
  output logic signed [31:0]   vel_x,
  output logic signed [31:0]   vel_y,
  output logic [31:0]          heading,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_t state, state_next;
  logic   issued, issued_next;

  logic [15:0]          angular_accel;
  logic [15:0]          linear_accel;
  logic [15:0]          drag_factor;
  logic signed [31:0]   position_x;
  logic signed [31:0]   position_y;
  logic signed [31:0]   velocity_x;
  logic signed [31:0]   velocity_y;
  logic [31:0]          heading_angle;

  logic [15:0]          dt_r;
  logic [13:0]          steer_mag;
  logic                 steer_neg;
  logic [29:0]          turn_part;
  logic [23:0]          accel_dt;
  logic signed [MCAND_W-1:0] cos_r;
  logic signed [MCAND_W-1:0] sin_r;

  logic signed [15:0]   steer_clamped;
  logic signed [15:0]   steer_abs;

  logic                      mult_start;
  logic signed [MCAND_W-1:0] mcand;
  logic [MIER_W-1:0]         mier;
  logic                      mult_done;
  logic signed [PROD_W-1:0]  prod;
  logic                      trig_start;
  logic                      trig_done;
  logic signed [MCAND_W-1:0] cos_val;
  logic signed [MCAND_W-1:0] sin_val;
  logic [31:0]               dturn;
  logic signed [32:0]        vel_sum;

  cks_serial_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mult_start),
    .mcand (mcand),
    .mier  (mier),
    .done  (mult_done),
    .prod  (prod)
  );

  cks_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .angle   (heading_angle),
    .done    (trig_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign dturn = prod[36:5];

  always_comb begin
    if (steer > 16'sd8192) begin
      steer_clamped = 16'sd8192;
    end else if (steer < -16'sd8192) begin
      steer_clamped = -16'sd8192;
    end else begin
      steer_clamped = steer;
    end
    steer_abs = steer_clamped[15] ? -steer_clamped : steer_clamped;
  end

  always_comb begin
    case (state)
      S_VY:    vel_sum = {velocity_y[31], velocity_y} + {{4{prod[PROD_W-1]}}, prod[PROD_W-1:30]};
      default: vel_sum = {velocity_x[31], velocity_x} + {{4{prod[PROD_W-1]}}, prod[PROD_W-1:30]};
    endcase
  end

  always_comb begin
    state_next = state;
    issued_next = issued;
    mult_start = 1'b0;
    trig_start = 1'b0;
    mcand = '0;
    mier = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_TURN_A;
          issued_next = 1'b0;
        end
      end
      S_TURN_A: begin
        mcand = MCAND_W'(steer_mag);
        mier = MIER_W'(angular_accel);
      end
      S_TURN_B: begin
        mcand = MCAND_W'(turn_part);
        mier = MIER_W'(dt_r);
      end
      S_ACCEL: begin
        mcand = MCAND_W'(linear_accel);
        mier = MIER_W'(dt_r);
      end
      S_VX: begin
        mcand = cos_r;
        mier = accel_dt;
      end
      S_VY: begin
        mcand = sin_r;
        mier = accel_dt;
      end
      S_DRAG_X: begin
        mcand = MCAND_W'(velocity_x);
        mier = MIER_W'(drag_factor);
      end
      S_DRAG_Y: begin
        mcand = MCAND_W'(velocity_y);
        mier = MIER_W'(drag_factor);
      end
      S_TRIG: begin
        if (!issued) begin
          trig_start = 1'b1;
          issued_next = 1'b1;
        end else if (trig_done) begin
          issued_next = 1'b0;
          state_next = S_VX;
        end
      end
      S_DONE: begin
        if (!(out_valid && out_stall)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (state != S_IDLE && state != S_TRIG && state != S_DONE) begin
      if (!issued) begin
        mult_start = 1'b1;
        issued_next = 1'b1;
      end else if (mult_done) begin
        issued_next = 1'b0;
        case (state)
          S_TURN_A: state_next = S_TURN_B;
          S_TURN_B: state_next = S_ACCEL;
          S_ACCEL:  state_next = S_TRIG;
          S_VX:     state_next = S_VY;
          S_VY:     state_next = S_DRAG_X;
          S_DRAG_X: state_next = S_DRAG_Y;
          default:  state_next = S_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      issued <= issued_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angular_accel <= '0;
      linear_accel <= '0;
      drag_factor <= 16'hffff;
      position_x <= '0;
      position_y <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
      heading_angle <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANGULAR: angular_accel <= cfg_data;
          REG_LINEAR:  linear_accel <= cfg_data;
          REG_DRAG:    drag_factor <= cfg_data;
          default:     ;
        endcase
      end
      if (state == S_DONE && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            position_x <= sat32({position_x[31], position_x} + {velocity_x[31], velocity_x});
            position_y <= sat32({position_y[31], position_y} + {velocity_y[31], velocity_y});
          end
        end
        S_TURN_B: begin
          if (issued && mult_done) begin
            heading_angle <= steer_neg ? heading_angle - dturn : heading_angle + dturn;
          end
        end
        S_VX: begin
          if (issued && mult_done) begin
            velocity_x <= sat32(vel_sum);
          end
        end
        S_VY: begin
          if (issued && mult_done) begin
            velocity_y <= sat32(vel_sum);
          end
        end
        S_DRAG_X: begin
          if (issued && mult_done) begin
            velocity_x <= prod[47:16];
          end
        end
        S_DRAG_Y: begin
          if (issued && mult_done) begin
            velocity_y <= prod[47:16];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      dt_r <= dt;
      steer_mag <= steer_abs[13:0];
      steer_neg <= steer_clamped[15];
    end
    if (state == S_TURN_A && issued && mult_done) begin
      turn_part <= prod[29:0];
    end
    if (state == S_ACCEL && issued && mult_done) begin
      accel_dt <= prod[31:8];
    end
    if (state == S_TRIG && issued && trig_done) begin
      cos_r <= cos_val;
      sin_r <= sin_val;
    end
    if (state == S_DONE && !(out_valid && out_stall)) begin
      pos_x <= position_x;
      pos_y <= position_y;
      vel_x <= velocity_x;
      vel_y <= velocity_y;
      heading <= heading_angle;
    end
  end

endmodule
